@@ sv/csl_pkg.sv @@
package csl_pkg;

  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  localparam logic [1:0] CLS_WORD = 2'd0;
  localparam logic [1:0] CLS_STR  = 2'd1;
  localparam logic [1:0] CLS_OP   = 2'd2;

  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  tok_byte;
    logic [1:0]  tok_class;
    logic [15:0] line_no;
    logic [15:0] start_col;
    logic        last;
  } out_t;

  // all results caused by one input item
  typedef struct packed {
    logic [1:0]           cnt;
    out_t [MaxRes-1:0]    res;
  } bundle_t;

  function automatic out_t make_res(logic [1:0] ev, logic [7:0] b, logic [1:0] cls,
                                    logic [15:0] line, logic [15:0] col);
    out_t r;
    r.event_res = ev;
    r.tok_byte  = b;
    r.tok_class = cls;
    r.line_no   = line;
    r.start_col = col;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

endpackage

@@ sv/csl_front.sv @@
module csl_front #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  csl_pkg::in_t     in_i,
  output logic             push_o,
  output csl_pkg::bundle_t push_data_o,
  input  logic             full_i
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_STR  = 2'd2;

  localparam logic [COUNTER_BITS-1:0] CntMax = '1;

  logic [1:0]              mode_q, mode_d;
  logic                    esc_q, esc_d;
  logic                    qsingle_q, qsingle_d;
  logic [COUNTER_BITS-1:0] line_q, line_d;
  logic [COUNTER_BITS-1:0] col_q, col_d;
  logic [COUNTER_BITS-1:0] tsc_q, tsc_d;

  logic              accept;
  logic [1:0]        n;
  csl_pkg::bundle_t  bundle;
  logic [7:0]        c;
  logic [7:0]        quote;
  logic              run_idle;
  logic [15:0]       line16;
  logic [COUNTER_BITS-1:0] col_inc;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_i.ch;
  assign quote      = qsingle_q ? csl_pkg::CH_SQUOTE : csl_pkg::CH_DQUOTE;
  assign line16     = 16'(line_q);
  assign col_inc    = (col_q == CntMax) ? col_q : col_q + 1'b1;

  always_comb begin
    mode_d    = mode_q;
    esc_d     = esc_q;
    qsingle_d = qsingle_q;
    line_d    = line_q;
    col_d     = col_q;
    tsc_d     = tsc_q;
    n         = 2'd0;
    bundle    = '0;
    run_idle  = 1'b0;

    case (mode_q)
      MODE_STR: begin
        col_d = col_inc;
        if (esc_q) begin
          esc_d = 1'b0;
          bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_CHAR, c, csl_pkg::CLS_STR,
                                            line16, 16'(tsc_q));
          n = n + 2'd1;
        end else if (c == csl_pkg::CH_BSLASH) begin
          esc_d = 1'b1;
        end else if (c == quote) begin
          bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_END, 8'd0, csl_pkg::CLS_STR,
                                            line16, 16'(tsc_q));
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end else begin
          bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_CHAR, c, csl_pkg::CLS_STR,
                                            line16, 16'(tsc_q));
          n = n + 2'd1;
        end
      end
      MODE_WORD: begin
        if (csl_pkg::is_word(c)) begin
          bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_CHAR, c, csl_pkg::CLS_WORD,
                                            line16, 16'(tsc_q));
          n = n + 2'd1;
          col_d = col_inc;
        end else begin
          // close the word, then treat the byte as if idle
          bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_END, 8'd0, csl_pkg::CLS_WORD,
                                            line16, 16'(tsc_q));
          n = n + 2'd1;
          mode_d   = MODE_IDLE;
          run_idle = 1'b1;
        end
      end
      default: begin
        mode_d   = MODE_IDLE;
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      if (csl_pkg::is_space(c)) begin
        if (c == csl_pkg::CH_NEWLINE) begin
          line_d = (line_q == CntMax) ? line_q : line_q + 1'b1;
          col_d  = COUNTER_BITS'(1);
        end else begin
          col_d = col_inc;
        end
      end else if (c == csl_pkg::CH_DQUOTE || c == csl_pkg::CH_SQUOTE) begin
        tsc_d     = col_q;
        qsingle_d = (c == csl_pkg::CH_SQUOTE);
        esc_d     = 1'b0;
        mode_d    = MODE_STR;
        col_d     = col_inc;
      end else if (csl_pkg::is_word(c)) begin
        tsc_d  = col_q;
        mode_d = MODE_WORD;
        bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_CHAR, c, csl_pkg::CLS_WORD,
                                          line16, 16'(col_q));
        n = n + 2'd1;
        col_d = col_inc;
      end else begin
        tsc_d = col_q;
        bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_CHAR, c, csl_pkg::CLS_OP,
                                          line16, 16'(col_q));
        n = n + 2'd1;
        bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_END, 8'd0, csl_pkg::CLS_OP,
                                          line16, 16'(col_q));
        n = n + 2'd1;
        col_d = col_inc;
      end
    end

    if (in_i.end_of_text) begin
      if (mode_d == MODE_WORD) begin
        bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_END, 8'd0, csl_pkg::CLS_WORD,
                                          line16, 16'(tsc_d));
        n = n + 2'd1;
      end else if (mode_d == MODE_STR) begin
        bundle.res[n] = csl_pkg::make_res(csl_pkg::EV_ERR, 8'd0, csl_pkg::CLS_STR,
                                          line16, 16'(tsc_d));
        n = n + 2'd1;
      end
      // back to the reset state for the next text
      mode_d    = MODE_IDLE;
      esc_d     = 1'b0;
      qsingle_d = 1'b0;
      line_d    = COUNTER_BITS'(1);
      col_d     = '0;
      tsc_d     = '0;
    end

    if (n != 2'd0) begin
      bundle.res[n - 2'd1].last = 1'b1;
    end
    bundle.cnt = n;
  end

  assign push_o      = accept && (n != 2'd0);
  assign push_data_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      esc_q     <= 1'b0;
      qsingle_q <= 1'b0;
      line_q    <= COUNTER_BITS'(1);
      col_q     <= '0;
      tsc_q     <= '0;
    end else if (accept) begin
      mode_q    <= mode_d;
      esc_q     <= esc_d;
      qsingle_q <= qsingle_d;
      line_q    <= line_d;
      col_q     <= col_d;
      tsc_q     <= tsc_d;
    end
  end

endmodule

@@ sv/csl_fifo.sv @@
module csl_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  csl_pkg::bundle_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output csl_pkg::bundle_t pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  csl_pkg::bundle_t mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ sv/csl_back.sv @@
module csl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  csl_pkg::bundle_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output csl_pkg::out_t    out_o
);

  csl_pkg::bundle_t cur_q;
  logic [1:0]       idx_q;
  logic             busy_q;
  logic             done;

  assign done        = out_ready_i && (idx_q == cur_q.cnt - 2'd1);
  assign q_pop_o     = q_valid_i && (!busy_q || done);
  assign out_valid_o = busy_q;
  assign out_o       = cur_q.res[idx_q];

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && done) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (busy_q && out_ready_i) begin
      // advance to the next result of the held bundle
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

@@ sv/char_stream_lexer.sv @@
// Channel  Signals                        Payload
// ------   -----------------------------  ------------------------------------
// input    in_valid_i / in_ready_o        in_i  : text byte, end-of-text flag
// output   out_valid_o / out_ready_i      out_o : token event, class, line, col
//
// One text byte is taken per cycle while the result queue has room; the
// front updates lexer state in that same cycle and queues the item's
// results (one to three) as one entry, or nothing when there are none.
// The output side drains one result per cycle while out_ready_i is high,
// handing out a byte's results in order. Reset clears lexer state and
// empties the queue. Either side may stall; the queue absorbs up to
// QUEUE_DEPTH entries of slack.
module char_stream_lexer #(
  parameter int unsigned COUNTER_BITS = 16,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  csl_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output csl_pkg::out_t out_o
);

  logic             push;
  logic             full;
  logic             pop;
  logic             q_valid;
  csl_pkg::bundle_t push_data;
  csl_pkg::bundle_t pop_data;

  csl_front #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  csl_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_data)
  );

  csl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

endmodule
